@@ rtl/core/rmlfw_pkg.sv @@
package rmlfw_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_PIXEL     = 2'd0,
    MODE_END_WRITE = 2'd1,
    MODE_NEXT_LINE = 2'd2,
    MODE_CLEAR     = 2'd3
  } mode_t;

  // Address unit operations
  typedef enum logic [1:0] {
    ADDR_HOLD,
    ADDR_LOAD,
    ADDR_INC,
    ADDR_ZERO
  } addr_op_t;

  // Frame memory strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  localparam int unsigned PIXELS_PER_BYTE = 8;
  localparam int unsigned BIT_W           = 3;   // bit within a byte
  localparam int unsigned COL_W           = 5;   // byte column from an 8-bit coordinate

  localparam logic [7:0] CMD_WRITE  = 8'h01;
  localparam logic [7:0] CMD_CLEAR  = 8'h04;
  localparam logic [7:0] WHITE_BYTE = 8'hFF;
  localparam logic [7:0] DUMMY_BYTE = 8'h00;

endpackage

@@ rtl/core/rmlfw_frame_mem.sv @@
module rmlfw_frame_mem
  import rmlfw_pkg::*;
#(
  parameter int unsigned DEPTH = 3024,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/rmlfw_addr_unit.sv @@
module rmlfw_addr_unit
  import rmlfw_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 18,
  parameter int unsigned AW         = 12
) (
  input  logic             clk,
  input  addr_op_t         op,
  input  logic [7:0]       line,
  input  logic [COL_W-1:0] col,
  output logic [AW-1:0]    addr
);

  logic [AW-1:0] addr_r;
  logic [AW-1:0] addr_nxt;

  // line * bytes-per-line + column, a step of one, zero, or hold
  always_comb begin
    unique case (op)
      ADDR_LOAD: addr_nxt = AW'(line) * AW'(LINE_BYTES) + AW'(col);
      ADDR_INC:  addr_nxt = addr_r + AW'(1);
      ADDR_ZERO: addr_nxt = '0;
      default:   addr_nxt = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  assign addr = addr_r;

endmodule

@@ rtl/core/rotated_memory_lcd_frame_writer.sv @@
// Pixel write: read, then write back; end of write and empty next-line finish in idle.
// Next line: write command (first line only), line number, each data word read and then
// emitted through the one frame memory port, the line's dummy, and the closing dummy last.
// A clear runs a white-fill sweep, then its command and dummy. Every item runs alone:
// in_stall stays high until its last word is loaded out, and out_stall can hold it there.
// Reset (sync, active low) starts a white-fill pass over all STORE_BYTES words.
module rotated_memory_lcd_frame_writer
  import rmlfw_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 144,
  parameter int unsigned PANEL_HEIGHT = 168
) (
  input  logic       clk,
  input  logic       rst_n,
  // item channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_view_x,
  input  logic [7:0] in_view_y,
  input  logic       in_pixel_value,
  // serial link word channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_link_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_transfer
);

  localparam int unsigned LINE_BYTES  = (PANEL_WIDTH + PIXELS_PER_BYTE - 1) / PIXELS_PER_BYTE;
  localparam int unsigned STORE_BYTES = LINE_BYTES * PANEL_HEIGHT;
  localparam int unsigned AW          = $clog2(STORE_BYTES);
  localparam int unsigned BCW         = $clog2(LINE_BYTES + 1);

  typedef enum logic [3:0] {
    S_START,    // zero the address, then sweep
    S_SWEEP,    // white-fill, one word a cycle
    S_IDLE,
    S_PX_RD,    // read the word holding the pixel
    S_PX_WR,    // write it back modified
    S_CMD,      // write command before the first line
    S_LNUM,     // 1-based line number
    S_DATA_RD,
    S_DATA_EM,
    S_DUMMY,    // per-line trailer
    S_TRAIL,    // closing dummy, releases chip select
    S_CLR_CMD,
    S_CLR_END
  } state_t;

  state_t           state_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_eot_r;
  logic [7:0]       dirty_first_r;
  logic [7:0]       dirty_past_end_r;
  logic             flush_pending_r;
  logic [7:0]       flush_line_r;
  logic [7:0]       flush_stop_r;
  logic             command_sent_r;
  logic             sweep_cmd_r;    // clear command words follow the sweep
  logic [BCW-1:0]   bc_r;           // data word within the line
  logic [BIT_W-1:0] bit_r;
  logic             val_r;

  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic             px_ok;
  logic [7:0]       hy_in;
  logic [7:0]       fl1;
  logic             line_final;
  addr_op_t         addr_op;
  logic [7:0]       line_sel;
  logic [COL_W-1:0] col_sel;
  logic [AW-1:0]    addr;
  mem_ctl_t         mem_ctl;
  logic [7:0]       wdata;
  logic [7:0]       rdata;
  logic [7:0]       px_mask;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // output register can take a new word this cycle
  assign out_free  = !out_valid_r || !out_stall;
  // a word is loaded into the output register this cycle
  assign out_load  = out_free && ((state_r == S_CMD) || (state_r == S_LNUM) ||
                                  (state_r == S_DATA_EM) || (state_r == S_DUMMY) ||
                                  (state_r == S_TRAIL) || (state_r == S_CLR_CMD) ||
                                  (state_r == S_CLR_END));

  // 90 degrees clockwise: hw_x = view_y, hw_y = H-1-view_x
  assign px_ok = (in_view_x < 8'(PANEL_HEIGHT)) &&
                 ({8'd0, in_view_y} < 16'(PANEL_WIDTH));
  assign hy_in = 8'(PANEL_HEIGHT - 1) - in_view_x;

  assign fl1        = flush_line_r + 8'd1;
  assign line_final = (fl1 >= flush_stop_r) || (fl1 >= 8'(PANEL_HEIGHT));

  // Shared address unit control
  assign line_sel = (state_r == S_IDLE) ? hy_in : flush_line_r;
  assign col_sel  = (state_r == S_IDLE) ? in_view_y[7:BIT_W] : '0;

  always_comb begin
    unique case (state_r)
      S_START: addr_op = ADDR_ZERO;
      S_SWEEP: addr_op = ADDR_INC;
      S_IDLE: begin
        if (in_accept && mode_t'(in_mode) == MODE_PIXEL) begin
          addr_op = ADDR_LOAD;
        end else if (in_accept && mode_t'(in_mode) == MODE_CLEAR) begin
          addr_op = ADDR_ZERO;
        end else begin
          addr_op = ADDR_HOLD;
        end
      end
      S_CMD, S_LNUM: addr_op = ADDR_LOAD;
      S_DATA_EM:     addr_op = out_free ? ADDR_INC : ADDR_HOLD;
      default:       addr_op = ADDR_HOLD;
    endcase
  end

  rmlfw_addr_unit #(
    .LINE_BYTES (LINE_BYTES),
    .AW         (AW)
  ) u_addr (
    .clk  (clk),
    .op   (addr_op),
    .line (line_sel),
    .col  (col_sel),
    .addr (addr)
  );

  // Frame memory: sweep and pixel write-back write, pixel and line read
  assign px_mask    = 8'd1 << bit_r;
  assign mem_ctl.we = (state_r == S_SWEEP) || (state_r == S_PX_WR);
  assign mem_ctl.re = (state_r == S_PX_RD) || (state_r == S_DATA_RD);
  assign wdata      = (state_r == S_SWEEP) ? WHITE_BYTE :
                      (val_r ? (rdata | px_mask) : (rdata & ~px_mask));

  rmlfw_frame_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_START;
      out_valid_r      <= 1'b0;
      dirty_first_r    <= 8'(PANEL_HEIGHT);
      dirty_past_end_r <= 8'd0;
      flush_pending_r  <= 1'b0;
      flush_line_r     <= 8'd0;
      flush_stop_r     <= 8'd0;
      command_sent_r   <= 1'b0;
      sweep_cmd_r      <= 1'b0;
      bc_r             <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_START: state_r <= S_SWEEP;
        S_SWEEP: begin
          if (addr == AW'(STORE_BYTES - 1)) begin
            state_r <= sweep_cmd_r ? S_CLR_CMD : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            unique case (mode_t'(in_mode))
              MODE_PIXEL: begin
                if (px_ok) begin
                  bit_r <= in_view_y[BIT_W-1:0];
                  val_r <= in_pixel_value;
                  if (hy_in < dirty_first_r) begin
                    dirty_first_r <= hy_in;
                  end
                  if (hy_in >= dirty_past_end_r) begin
                    dirty_past_end_r <= hy_in + 8'd1;
                  end
                  state_r <= S_PX_RD;
                end
              end
              MODE_END_WRITE: begin
                flush_line_r     <= dirty_first_r;
                flush_stop_r     <= dirty_past_end_r;
                flush_pending_r  <= (dirty_first_r < dirty_past_end_r);
                command_sent_r   <= 1'b0;
                dirty_first_r    <= 8'(PANEL_HEIGHT);
                dirty_past_end_r <= 8'd0;
              end
              MODE_NEXT_LINE: begin
                if (flush_pending_r) begin
                  state_r <= command_sent_r ? S_LNUM : S_CMD;
                end
              end
              MODE_CLEAR: begin
                dirty_first_r    <= 8'(PANEL_HEIGHT);
                dirty_past_end_r <= 8'd0;
                flush_pending_r  <= 1'b0;
                sweep_cmd_r      <= 1'b1;
                state_r          <= S_SWEEP;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_PX_RD: state_r <= S_PX_WR;
        S_PX_WR: state_r <= S_IDLE;
        S_CMD: begin
          if (out_free) begin
            out_byte_r     <= CMD_WRITE;
            out_last_r     <= 1'b0;
            out_eot_r      <= 1'b0;
            command_sent_r <= 1'b1;
            state_r        <= S_LNUM;
          end
        end
        S_LNUM: begin
          if (out_free) begin
            out_byte_r  <= fl1;
            out_last_r  <= 1'b0;
            out_eot_r   <= 1'b0;
            bc_r        <= '0;
            state_r     <= S_DATA_RD;
          end
        end
        S_DATA_RD: state_r <= S_DATA_EM;
        S_DATA_EM: begin
          if (out_free) begin
            out_byte_r  <= rdata;
            out_last_r  <= 1'b0;
            out_eot_r   <= 1'b0;
            bc_r        <= bc_r + BCW'(1);
            state_r     <= (bc_r == BCW'(LINE_BYTES - 1)) ? S_DUMMY : S_DATA_RD;
          end
        end
        S_DUMMY: begin
          if (out_free) begin
            out_byte_r   <= DUMMY_BYTE;
            out_last_r   <= !line_final;
            out_eot_r    <= 1'b0;
            flush_line_r <= fl1;
            state_r      <= line_final ? S_TRAIL : S_IDLE;
          end
        end
        S_TRAIL: begin
          if (out_free) begin
            out_byte_r      <= DUMMY_BYTE;
            out_last_r      <= 1'b1;
            out_eot_r       <= 1'b1;
            flush_pending_r <= 1'b0;
            state_r         <= S_IDLE;
          end
        end
        S_CLR_CMD: begin
          if (out_free) begin
            out_byte_r  <= CMD_CLEAR;
            out_last_r  <= 1'b0;
            out_eot_r   <= 1'b0;
            sweep_cmd_r <= 1'b0;
            state_r     <= S_CLR_END;
          end
        end
        S_CLR_END: begin
          if (out_free) begin
            out_byte_r  <= DUMMY_BYTE;
            out_last_r  <= 1'b1;
            out_eot_r   <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_link_byte       = out_byte_r;
  assign out_last_of_run     = out_last_r;
  assign out_end_of_transfer = out_eot_r;

`ifndef SYNTH
  // chip select release always closes the item's run
  a_eot_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_transfer) |-> out_last_of_run)
    else $error("end of transfer without last of run");

  // a pending flush has a line left inside the panel until its closing dummy
  a_flush_range: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_pending_r && (state_r != S_TRAIL)) |->
      ((flush_line_r < flush_stop_r) && (flush_stop_r <= 8'(PANEL_HEIGHT))))
    else $error("pending flush outside its range");

  // dirty range is either empty at its reset value or well formed
  a_dirty_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((dirty_first_r < dirty_past_end_r) && (dirty_past_end_r <= 8'(PANEL_HEIGHT))) ||
    ((dirty_first_r == 8'(PANEL_HEIGHT)) && (dirty_past_end_r == 8'd0)))
    else $error("dirty range corrupt");
`endif

endmodule

@@ test/frame_writer_link_checker.sv @@
module frame_writer_link_checker
  import rmlfw_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 144,
  parameter int unsigned PANEL_HEIGHT = 168
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_view_x,
  input  logic [7:0]  in_view_y,
  input  logic        in_pixel_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_link_byte,
  input  logic        out_last_of_run,
  input  logic        out_end_of_transfer,
  output int unsigned mismatch_count,
  output int unsigned words_due
);

  localparam int unsigned LINE_BYTES  =
    (PANEL_WIDTH + PIXELS_PER_BYTE - 1) / PIXELS_PER_BYTE;
  localparam int unsigned STORE_BYTES = LINE_BYTES * PANEL_HEIGHT;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0] link_byte;
    logic       last_of_run;
    logic       end_of_transfer;
  } link_word_t;

  logic [7:0]  frame_copy [STORE_BYTES];
  int unsigned dirty_lo;
  int unsigned dirty_hi;
  int unsigned line_next;
  int unsigned line_stop;
  logic        flush_armed;
  logic        write_cmd_done;
  link_word_t  link_words_due [$];
  int unsigned errs = 0;

  task automatic whiten_frame();
    foreach (frame_copy[i]) frame_copy[i] = WHITE_BYTE;
    dirty_lo = PANEL_HEIGHT;
    dirty_hi = 0;
  endtask

  task automatic queue_word(input logic [7:0] b, input logic eot);
    link_word_t w;
    w.link_byte       = b;
    w.last_of_run     = 1'b0;
    w.end_of_transfer = eot;
    link_words_due.push_back(w);
  endtask

  // Updates the shadow frame and queues the link words the item causes
  task automatic predict_link_words(input mode_t m, input logic [7:0] lx,
                                    input logic [7:0] ly, input logic pv);
    int unsigned hx;
    int unsigned hy;
    int unsigned idx;
    int unsigned n0;
    n0 = link_words_due.size();
    case (m)
      MODE_PIXEL: begin
        if (lx < PANEL_HEIGHT && ly < PANEL_WIDTH) begin
          hx  = ly;
          hy  = PANEL_HEIGHT - 1 - lx;
          idx = hy * LINE_BYTES + hx / PIXELS_PER_BYTE;
          frame_copy[idx][hx % PIXELS_PER_BYTE] = pv;
          if (hy < dirty_lo) dirty_lo = hy;
          if (hy >= dirty_hi) dirty_hi = hy + 1;
        end
      end
      MODE_END_WRITE: begin
        line_next      = dirty_lo;
        line_stop      = dirty_hi;
        flush_armed    = (dirty_lo < dirty_hi);
        write_cmd_done = 1'b0;
        dirty_lo       = PANEL_HEIGHT;
        dirty_hi       = 0;
      end
      MODE_NEXT_LINE: begin
        if (flush_armed) begin
          if (!write_cmd_done) begin
            queue_word(CMD_WRITE, 1'b0);
            write_cmd_done = 1'b1;
          end
          queue_word(8'(line_next + 1), 1'b0);
          for (int unsigned i = 0; i < LINE_BYTES; i++) begin
            idx = line_next * LINE_BYTES + i;
            queue_word(idx < STORE_BYTES ? frame_copy[idx] : 8'h00, 1'b0);
          end
          queue_word(DUMMY_BYTE, 1'b0);
          line_next++;
          if (line_next >= line_stop || line_next >= PANEL_HEIGHT) begin
            queue_word(DUMMY_BYTE, 1'b1);
            flush_armed = 1'b0;
          end
        end
      end
      default: begin
        whiten_frame();
        flush_armed = 1'b0;
        queue_word(CMD_CLEAR, 1'b0);
        queue_word(DUMMY_BYTE, 1'b1);
      end
    endcase
    if (link_words_due.size() > n0)
      link_words_due[link_words_due.size() - 1].last_of_run = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    link_word_t got;
    link_word_t want;
    if (!rst_n) begin
      whiten_frame();
      line_next      = 0;
      line_stop      = 0;
      flush_armed    = 1'b0;
      write_cmd_done = 1'b0;
      link_words_due.delete();
    end else begin
      // input first: a word accepted now only adds to the tail
      if (in_valid && !in_stall)
        predict_link_words(mode_t'(in_mode), in_view_x, in_view_y, in_pixel_value);
      if (out_valid && !out_stall) begin
        got.link_byte       = out_link_byte;
        got.last_of_run     = out_last_of_run;
        got.end_of_transfer = out_end_of_transfer;
        if (link_words_due.size() == 0) begin
          if (errs < REPORT_MAX)
            $display("unexpected link word: byte %02h last %0b eot %0b",
                     got.link_byte, got.last_of_run, got.end_of_transfer);
          errs++;
        end else begin
          want = link_words_due.pop_front();
          if (got !== want) begin
            if (errs < REPORT_MAX)
              $display("link word mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                       want.link_byte, want.last_of_run, want.end_of_transfer,
                       got.link_byte, got.last_of_run, got.end_of_transfer);
            errs++;
          end
        end
      end
    end
    mismatch_count <= errs;
    words_due      <= link_words_due.size();
  end

endmodule

@@ test/rotated_memory_lcd_frame_writer_tb.sv @@
module rotated_memory_lcd_frame_writer_tb;
  import rmlfw_pkg::*;

  localparam int unsigned PANEL_WIDTH       = 144;
  localparam int unsigned PANEL_HEIGHT      = 168;
  localparam int unsigned RANDOM_ITEMS      = 500;
  localparam int unsigned CYCLE_LIMIT       = 5_000_000;
  // receiver hold-off: long enough to back the block up into its input
  localparam int unsigned HOLD_AFTER_WORDS  = 150;
  localparam int unsigned HOLD_CYCLES       = 400;
  // sender pause point, counted in accepted input words
  localparam int unsigned PAUSE_AFTER_ITEMS = 250;
  localparam int unsigned DRAIN_CYCLES      = 64;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] in_mode        = MODE_PIXEL;
  logic [7:0] in_view_x      = 8'h00;
  logic [7:0] in_view_y      = 8'h00;
  logic       in_pixel_value = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_link_byte;
  logic       out_last_of_run;
  logic       out_end_of_transfer;

  int unsigned fail_count;
  int unsigned words_due;

  int unsigned cycle_cnt  = 0;
  int unsigned words_seen = 0;
  int unsigned items_sent = 0;
  logic        hold_done  = 1'b0;
  logic        tx_calm    = 1'b0;

  // Stimulus-side view of the dirty range: tells the sequencer how many
  // next-line words a flush needs. Prediction lives in the checker.
  int unsigned trk_lo    = PANEL_HEIGHT;
  int unsigned trk_hi    = 0;
  int unsigned trk_lines = 0;

  rotated_memory_lcd_frame_writer #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_view_x          (in_view_x),
    .in_view_y          (in_view_y),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_link_byte      (out_link_byte),
    .out_last_of_run    (out_last_of_run),
    .out_end_of_transfer(out_end_of_transfer)
  );

  frame_writer_link_checker #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) i_link_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_view_x          (in_view_x),
    .in_view_y          (in_view_y),
    .in_pixel_value     (in_pixel_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_link_byte      (out_link_byte),
    .out_last_of_run    (out_last_of_run),
    .out_end_of_transfer(out_end_of_transfer),
    .mismatch_count     (fail_count),
    .words_due          (words_due)
  );

  // 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog; covers the white-fill after reset and every clear as well
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output words taken, only used to time the receiver hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) words_seen++;
  end

  // Gap before an input word: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Receiver stall length, never zero
  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Receiver pacing. The hold-off is counted here, in cycles, while the
  // sender carries on offering words.
  initial begin : rx_pacing
    @(posedge clk);
    forever begin
      if (!hold_done && words_seen >= HOLD_AFTER_WORDS) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 7) == 0) begin
        // stretch with no stall at all
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (stall_len()) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic track_word(input mode_t m, input logic [7:0] x, input logic [7:0] y);
    int unsigned hy;
    case (m)
      MODE_PIXEL: begin
        if (x < PANEL_HEIGHT && y < PANEL_WIDTH) begin
          hy = PANEL_HEIGHT - 1 - x;
          if (hy < trk_lo) trk_lo = hy;
          if (hy >= trk_hi) trk_hi = hy + 1;
        end
      end
      MODE_END_WRITE: begin
        trk_lines = (trk_lo < trk_hi) ? trk_hi - trk_lo : 0;
        trk_lo    = PANEL_HEIGHT;
        trk_hi    = 0;
      end
      MODE_NEXT_LINE: if (trk_lines != 0) trk_lines--;
      default: begin
        trk_lo    = PANEL_HEIGHT;
        trk_hi    = 0;
        trk_lines = 0;
      end
    endcase
  endtask

  // Offers one input word and holds it until the block takes it
  task automatic send_word(input mode_t m, input logic [7:0] x, input logic [7:0] y,
                           input logic v);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= m;
    in_view_x      <= x;
    in_view_y      <= y;
    in_pixel_value <= v;
    do @(posedge clk); while (in_stall);
    track_word(m, x, y);
    items_sent++;
  endtask

  // Pixel near a line cluster; some stray ones land anywhere, off-frame too
  task automatic send_pixel(input int unsigned base, input int unsigned spread);
    if ($urandom_range(0, 99) < 8)
      send_word(MODE_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    else
      send_word(MODE_PIXEL, 8'(base + $urandom_range(0, spread)),
                8'($urandom_range(0, PANEL_WIDTH - 1)), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned pick;
    int unsigned spread;
    int unsigned base;
    int unsigned burst;
    logic        abort;
    logic        paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // logical column 0 is the bottom hardware line; both row extremes
    send_word(MODE_PIXEL, 8'd0, 8'd0, 1'b0);
    send_word(MODE_PIXEL, 8'd0, 8'd143, 1'b0);
    // off-frame pixels, dropped
    send_word(MODE_PIXEL, 8'd168, 8'd5, 1'b0);
    send_word(MODE_PIXEL, 8'd5, 8'd144, 1'b0);
    send_word(MODE_PIXEL, 8'd255, 8'd255, 1'b1);
    // single-line flush of the last line
    send_word(MODE_END_WRITE, 8'd0, 8'd0, 1'b0);
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
    // nothing pending; then an empty range latched
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
    send_word(MODE_END_WRITE, 8'd0, 8'd0, 1'b0);
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
    // top two lines, white write included
    send_word(MODE_PIXEL, 8'd167, 8'd0, 1'b0);
    send_word(MODE_PIXEL, 8'd166, 8'd143, 1'b1);
    send_word(MODE_END_WRITE, 8'd0, 8'd0, 1'b0);
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
    // store changes mid-flush, the second line must carry it
    send_word(MODE_PIXEL, 8'd166, 8'd1, 1'b0);
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
    // new range latched while one is pending: write command again
    send_word(MODE_PIXEL, 8'd100, 8'd50, 1'b0);
    send_word(MODE_PIXEL, 8'd90, 8'd60, 1'b0);
    send_word(MODE_END_WRITE, 8'd0, 8'd0, 1'b0);
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
    send_word(MODE_PIXEL, 8'd80, 8'd70, 1'b0);
    send_word(MODE_PIXEL, 8'd78, 8'd71, 1'b1);
    send_word(MODE_END_WRITE, 8'd0, 8'd0, 1'b0);
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
    // clear cancels the pending flush
    send_word(MODE_CLEAR, 8'd0, 8'd0, 1'b0);
    send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);

    // --- random ---
    r = items_sent;
    while (items_sent < r + RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 9) == 0);
      pick    = $urandom_range(0, 99);
      if (pick < 72) begin
        // well-formed update: a burst of pixels, latch, then flush it, now and then cut short
        spread = $urandom_range(0, 99);
        if (spread < 85)      spread = $urandom_range(0, 3);
        else if (spread < 97) spread = $urandom_range(4, 15);
        else                  spread = $urandom_range(16, 60);
        base  = $urandom_range(0, PANEL_HEIGHT - 1);
        burst = $urandom_range(1, 10);
        repeat (burst) send_pixel(base, spread);
        send_word(MODE_END_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        abort = ($urandom_range(0, 9) == 0);
        while (trk_lines != 0) begin
          if (abort && $urandom_range(0, 2) == 0) break;
          send_word(MODE_NEXT_LINE, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 7) == 0) send_pixel(base, spread);
        end
        if (abort) begin
          case ($urandom_range(0, 2))
            0: send_word(MODE_CLEAR, 8'd0, 8'd0, 1'b0);
            1: send_word(MODE_END_WRITE, 8'd0, 8'd0, 1'b0);
            default: ;
          endcase
        end
        // a spare next-line now and then, usually with nothing pending
        if ($urandom_range(0, 4) == 0) send_word(MODE_NEXT_LINE, 8'd0, 8'd0, 1'b0);
      end else if (pick < 98) begin
        // noise: any of the cheap modes with any field values
        send_word(mode_t'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_word(MODE_CLEAR, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      // sender stands back once until the link has caught up
      if (!paused && items_sent >= PAUSE_AFTER_ITEMS) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0) @(posedge clk);
      end
    end

    // --- drain and verdict ---
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_due == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
